// File: sv/stereo_block_match_disparity_unit_assert.svh
// Assertion macros shared by the stereo block matching RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef STEREO_BLOCK_MATCH_DISPARITY_UNIT_ASSERT_SVH
`define STEREO_BLOCK_MATCH_DISPARITY_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stereo block match: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SBM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stereo block match: next-cycle check failed");

`endif

// File: sv/sbm_pkg.sv
package sbm_pkg;

    // Default sizing of the line stores and the disparity search.
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_WINDOW_DEF = 15;
    localparam int MAX_DISP_DEF   = 64;

    // Largest frame height that the row counter supports.
    localparam int ROW_LIMIT = 1024;

    // Configuration register indexes.
    localparam logic [2:0] CFG_COST_MODE       = 3'd0;
    localparam logic [2:0] CFG_WINDOW_HALF     = 3'd1;
    localparam logic [2:0] CFG_DISPARITY_COUNT = 3'd2;
    localparam logic [2:0] CFG_IMAGE_WIDTH     = 3'd3;
    localparam logic [2:0] CFG_IMAGE_HEIGHT    = 3'd4;

    // Configuration values after reset.
    localparam logic        COST_MODE_RST       = 1'b0;
    localparam logic [2:0]  WINDOW_HALF_RST     = 3'd3;
    localparam logic [6:0]  DISPARITY_COUNT_RST = 7'd64;
    localparam logic [10:0] IMAGE_WIDTH_RST     = 11'd640;
    localparam logic [10:0] IMAGE_HEIGHT_RST    = 11'd480;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } sbm_state_t;

    // Flags that travel with each window sample through the cost pipeline.
    typedef struct packed {
        logic valid;
        logic zero;
        logic last_d;
        logic last_all;
    } sbm_tok_t;

endpackage

// File: sv/sbm_line_store.sv
module sbm_line_store #(
    parameter int DEPTH = sbm_pkg::MAX_WINDOW_DEF * sbm_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(sbm_pkg::MAX_WINDOW_DEF * sbm_pkg::MAX_WIDTH_DEF)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/stereo_block_match_disparity_unit.sv
// Channel   | Direction | Handshake            | Contents
// ----------+-----------+----------------------+----------------------------------------
// in        | in        | in_valid / in_ready  | left_pixel, right_pixel, frame_start
// out       | out       | out_valid / out_ready| disparity, pixel_row, pixel_col, best_cost
// cfg       | in        | cfg_we               | cfg_index, cfg_data
//
// A pixel whose window is complete is scanned over (2h+1)^2 samples for each of nd
// disparities, h being the window half; one sample of each line store is read per cycle.
// A pixel with no result goes from ST_STEP to ST_IDLE. Reset is asynchronous and clears
// control state only; the line stores hold nothing defined until written. A result waiting
// on out_ready does not block the next request, but the following result waits for it.
module stereo_block_match_disparity_unit #(
    parameter int MAX_WIDTH  = sbm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_WINDOW = sbm_pkg::MAX_WINDOW_DEF,
    parameter int MAX_DISP   = sbm_pkg::MAX_DISP_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  left_pixel,
    input  logic [7:0]  right_pixel,
    input  logic        frame_start,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  disparity,
    output logic [9:0]  pixel_row,
    output logic [9:0]  pixel_col,
    output logic [23:0] best_cost,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    `include "stereo_block_match_disparity_unit_assert.svh"

    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int SW    = $clog2(MAX_WINDOW);
    localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = $clog2(MAX_DISP);
    localparam int NDW   = $clog2(MAX_DISP + 1);
    localparam int HMAX  = (MAX_WINDOW - 1) / 2;
    localparam int ACC_W = $clog2(MAX_WINDOW * MAX_WINDOW * 65025 + 1);

    // Configuration registers.
    logic        cost_mode_reg;
    logic [2:0]  window_half_reg;
    logic [6:0]  disparity_count_reg;
    logic [10:0] image_width_reg;
    logic [10:0] image_height_reg;

    // Effective geometry.
    logic [CW-1:0]  eff_w;
    logic [10:0]    eff_ht;
    logic [2:0]     eff_h;
    logic [3:0]     two_h;
    logic [NDW-1:0] eff_nd;
    logic [DW-1:0]  nd_m1;

    // Position counters and the current pixel.
    logic [9:0]    row_reg;
    logic [CW-1:0] col_reg;
    logic [SW-1:0] rslot_reg;
    logic [9:0]    cur_row_reg;
    logic [CW-1:0] cur_col_reg;
    logic [SW-1:0] cur_slot_reg;
    logic          emit_reg;

    // Position normalisation at acceptance.
    logic [9:0]    r_a;
    logic [CW-1:0] c_a;
    logic [SW-1:0] s_a;
    logic [10:0]   r_b;
    logic [CW-1:0] c_b;
    logic [SW-1:0] s_b;
    logic [9:0]    r_c;
    logic [SW-1:0] s_c;
    logic          emit_next;

    // Advance after the pixel.
    logic [CW:0]   col_inc;
    logic [10:0]   row_inc;
    logic [SW-1:0] slot_inc;
    logic [9:0]    row_next;
    logic [CW-1:0] col_next;
    logic [SW-1:0] rslot_next;

    // Window scan.
    sbm_pkg::sbm_state_t state_reg;
    sbm_pkg::sbm_state_t state_next;
    logic [DW-1:0] d_reg;
    logic [3:0]    dx_reg;
    logic [3:0]    dy_reg;
    logic [CW-1:0] lx_reg;
    logic [SW-1:0] win_slot_reg;
    logic [SW-1:0] win_start_reg;
    logic [CW-1:0] c0_reg;
    logic [SW:0]   rs_ext;
    logic [SW-1:0] rs0;
    logic [SW-1:0] win_slot_inc;
    logic [CW-1:0] rx;
    logic          issue;
    logic          issue_last;
    logic          accept;
    logic          load_out;

    // Memory ports.
    logic [AW-1:0] waddr;
    logic [AW-1:0] laddr;
    logic [AW-1:0] raddr;
    logic [7:0]    lv_data;
    logic [7:0]    rv_data;

    // Cost pipeline.
    sbm_pkg::sbm_tok_t tok0;
    sbm_pkg::sbm_tok_t s1_tok_reg;
    sbm_pkg::sbm_tok_t s2_tok_reg;
    logic [DW-1:0]    s1_d_reg;
    logic [DW-1:0]    s2_d_reg;
    logic [7:0]       rv;
    logic [7:0]       ad;
    logic [15:0]      term_next;
    logic [15:0]      term_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] sum;
    logic [ACC_W-1:0] best_reg;
    logic [DW-1:0]    best_d_reg;

    // Result register.
    logic        out_valid_reg;
    logic [5:0]  out_disp_reg;
    logic [9:0]  out_row_reg;
    logic [9:0]  out_col_reg;
    logic [23:0] out_cost_reg;

    function automatic logic [AW-1:0] slot_addr(input logic [SW-1:0] s, input logic [CW-1:0] c);
        slot_addr = AW'(s) * AW'(MAX_WIDTH) + AW'(c);
    endfunction

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cost_mode_reg       <= sbm_pkg::COST_MODE_RST;
            window_half_reg     <= sbm_pkg::WINDOW_HALF_RST;
            disparity_count_reg <= sbm_pkg::DISPARITY_COUNT_RST;
            image_width_reg     <= sbm_pkg::IMAGE_WIDTH_RST;
            image_height_reg    <= sbm_pkg::IMAGE_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sbm_pkg::CFG_COST_MODE:       cost_mode_reg       <= cfg_data[0];
                sbm_pkg::CFG_WINDOW_HALF:     window_half_reg     <= cfg_data[2:0];
                sbm_pkg::CFG_DISPARITY_COUNT: disparity_count_reg <= cfg_data[6:0];
                sbm_pkg::CFG_IMAGE_WIDTH:     image_width_reg     <= cfg_data;
                sbm_pkg::CFG_IMAGE_HEIGHT:    image_height_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Saturate the configuration into the supported ranges.
    always_comb
    begin
        if (image_width_reg == 11'd0)
            eff_w = CW'(1);
        else if (32'(image_width_reg) > MAX_WIDTH)
            eff_w = CW'(MAX_WIDTH);
        else
            eff_w = CW'(image_width_reg);

        if (image_height_reg == 11'd0)
            eff_ht = 11'd1;
        else if (32'(image_height_reg) > sbm_pkg::ROW_LIMIT)
            eff_ht = 11'(sbm_pkg::ROW_LIMIT);
        else
            eff_ht = image_height_reg;

        if (32'(window_half_reg) > HMAX)
            eff_h = 3'(HMAX);
        else
            eff_h = window_half_reg;

        if (disparity_count_reg == 7'd0)
            eff_nd = NDW'(1);
        else if (32'(disparity_count_reg) > MAX_DISP)
            eff_nd = NDW'(MAX_DISP);
        else
            eff_nd = NDW'(disparity_count_reg);
    end

    assign two_h = {eff_h, 1'b0};
    assign nd_m1 = DW'(eff_nd - NDW'(1));

    // Bring the position counters into the current geometry before storing the pixel.
    always_comb
    begin
        r_a = frame_start ? 10'd0 : row_reg;
        c_a = frame_start ? '0 : col_reg;
        s_a = frame_start ? '0 : rslot_reg;
        if (c_a >= eff_w)
        begin
            c_b = '0;
            r_b = {1'b0, r_a} + 11'd1;
            s_b = (s_a == SW'(MAX_WINDOW - 1)) ? '0 : s_a + SW'(1);
        end
        else
        begin
            c_b = c_a;
            r_b = {1'b0, r_a};
            s_b = s_a;
        end
        if (r_b >= eff_ht)
        begin
            r_c = 10'd0;
            s_c = '0;
        end
        else
        begin
            r_c = r_b[9:0];
            s_c = s_b;
        end
        emit_next = (r_c >= 10'(two_h)) && (32'(c_b) >= 32'(two_h));
    end

    // Advance the counters past the pixel just taken.
    always_comb
    begin
        col_inc  = {1'b0, cur_col_reg} + (CW + 1)'(1);
        row_inc  = {1'b0, cur_row_reg} + 11'd1;
        slot_inc = (cur_slot_reg == SW'(MAX_WINDOW - 1)) ? '0 : cur_slot_reg + SW'(1);
        if (col_inc >= {1'b0, eff_w})
        begin
            col_next = '0;
            if (row_inc >= eff_ht)
            begin
                row_next   = 10'd0;
                rslot_next = '0;
            end
            else
            begin
                row_next   = row_inc[9:0];
                rslot_next = slot_inc;
            end
        end
        else
        begin
            col_next   = col_inc[CW-1:0];
            row_next   = cur_row_reg;
            rslot_next = cur_slot_reg;
        end
    end

    // First window row in the circular store.
    always_comb
    begin
        rs_ext = {1'b0, cur_slot_reg};
        if (rs_ext >= (SW + 1)'(two_h))
            rs0 = SW'(rs_ext - (SW + 1)'(two_h));
        else
            rs0 = SW'(rs_ext + (SW + 1)'(MAX_WINDOW) - (SW + 1)'(two_h));
    end

    assign win_slot_inc = (win_slot_reg == SW'(MAX_WINDOW - 1)) ? '0 : win_slot_reg + SW'(1);

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sbm_pkg::ST_IDLE:
                if (in_valid)
                    state_next = sbm_pkg::ST_STEP;
            sbm_pkg::ST_STEP:
                state_next = emit_reg ? sbm_pkg::ST_SCAN : sbm_pkg::ST_IDLE;
            sbm_pkg::ST_SCAN:
                if (issue_last)
                    state_next = sbm_pkg::ST_DRAIN;
            sbm_pkg::ST_DRAIN:
                if (s2_tok_reg.valid && s2_tok_reg.last_all)
                    state_next = sbm_pkg::ST_DONE;
            sbm_pkg::ST_DONE:
                if (!out_valid_reg || out_ready)
                    state_next = sbm_pkg::ST_IDLE;
            default:
                state_next = sbm_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ready = 1'b0;
        issue    = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            sbm_pkg::ST_IDLE:  in_ready = 1'b1;
            sbm_pkg::ST_SCAN:  issue = 1'b1;
            sbm_pkg::ST_DONE:  load_out = !out_valid_reg || out_ready;
            default: ;
        endcase
    end

    assign accept     = in_valid && in_ready;
    assign issue_last = (dx_reg == two_h) && (dy_reg == two_h) && (d_reg == nd_m1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sbm_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Position counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= 10'd0;
            col_reg   <= '0;
            rslot_reg <= '0;
            emit_reg  <= 1'b0;
        end
        else if (accept)
        begin
            emit_reg <= emit_next;
        end
        else if (state_reg == sbm_pkg::ST_STEP)
        begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            rslot_reg <= rslot_next;
        end
    end

    // Current pixel position.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_row_reg  <= r_c;
            cur_col_reg  <= c_b;
            cur_slot_reg <= s_c;
        end
    end

    // Window scan counters: dx fastest, then dy, then disparity.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_reg  <= '0;
            dx_reg <= 4'd0;
            dy_reg <= 4'd0;
        end
        else if (state_reg == sbm_pkg::ST_STEP)
        begin
            d_reg  <= '0;
            dx_reg <= 4'd0;
            dy_reg <= 4'd0;
        end
        else if (issue)
        begin
            if (dx_reg == two_h)
            begin
                dx_reg <= 4'd0;
                if (dy_reg == two_h)
                begin
                    dy_reg <= 4'd0;
                    d_reg  <= d_reg + DW'(1);
                end
                else
                begin
                    dy_reg <= dy_reg + 4'd1;
                end
            end
            else
            begin
                dx_reg <= dx_reg + 4'd1;
            end
        end
    end

    // Window addresses follow the scan counters.
    always_ff @(posedge clk)
    begin
        if (state_reg == sbm_pkg::ST_STEP)
        begin
            lx_reg        <= cur_col_reg - CW'(two_h);
            c0_reg        <= cur_col_reg - CW'(two_h);
            win_slot_reg  <= rs0;
            win_start_reg <= rs0;
        end
        else if (issue)
        begin
            if (dx_reg == two_h)
            begin
                lx_reg <= c0_reg;
                if (dy_reg == two_h)
                    win_slot_reg <= win_start_reg;
                else
                    win_slot_reg <= win_slot_inc;
            end
            else
            begin
                lx_reg <= lx_reg + CW'(1);
            end
        end
    end

    // Line stores.
    assign rx    = lx_reg - CW'(d_reg);
    assign waddr = slot_addr(s_c, c_b);
    assign laddr = slot_addr(win_slot_reg, lx_reg);
    assign raddr = slot_addr(win_slot_reg, rx);

    sbm_line_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_left_store (
        .clk   (clk),
        .we    (accept),
        .waddr (waddr),
        .wdata (left_pixel),
        .raddr (laddr),
        .rdata (lv_data)
    );

    sbm_line_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_right_store (
        .clk   (clk),
        .we    (accept),
        .waddr (waddr),
        .wdata (right_pixel),
        .raddr (raddr),
        .rdata (rv_data)
    );

    // Flags of the sample issued this cycle.
    always_comb
    begin
        tok0.valid    = issue;
        tok0.zero     = 32'(lx_reg) < 32'(d_reg);
        tok0.last_d   = (dx_reg == two_h) && (dy_reg == two_h);
        tok0.last_all = issue_last;
    end

    // Absolute or squared difference of one sample pair.
    always_comb
    begin
        rv        = s1_tok_reg.zero ? 8'd0 : rv_data;
        ad        = (lv_data > rv) ? lv_data - rv : rv - lv_data;
        term_next = cost_mode_reg ? 16'(ad * ad) : {8'd0, ad};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tok_reg <= '0;
            s2_tok_reg <= '0;
        end
        else
        begin
            s1_tok_reg <= tok0;
            s2_tok_reg <= s1_tok_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_d_reg <= d_reg;
        s2_d_reg <= s1_d_reg;
        term_reg <= term_next;
    end

    // Accumulate each disparity's cost and keep the first minimum.
    assign sum = acc_reg + ACC_W'(term_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == sbm_pkg::ST_STEP)
        begin
            acc_reg <= '0;
        end
        else if (s2_tok_reg.valid)
        begin
            if (s2_tok_reg.last_d)
            begin
                acc_reg <= '0;
                if ((s2_d_reg == '0) || (sum < best_reg))
                begin
                    best_reg   <= sum;
                    best_d_reg <= s2_d_reg;
                end
            end
            else
            begin
                acc_reg <= sum;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_disp_reg <= 6'(best_d_reg);
            out_row_reg  <= cur_row_reg - 10'(eff_h);
            out_col_reg  <= 10'(cur_col_reg - CW'(eff_h));
            out_cost_reg <= 24'(best_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign disparity = out_disp_reg;
    assign pixel_row = out_row_reg;
    assign pixel_col = out_col_reg;
    assign best_cost = out_cost_reg;

    // Checks on the sequencer and the cost pipeline.
    `SBM_ASSERT_IMP(a_pipe_in_scan, s1_tok_reg.valid, (state_reg == sbm_pkg::ST_SCAN) || (state_reg == sbm_pkg::ST_DRAIN))
    `SBM_ASSERT_IMP(a_pipe_empty_idle, state_reg == sbm_pkg::ST_IDLE, !s1_tok_reg.valid && !s2_tok_reg.valid)
    `SBM_ASSERT_IMP(a_disp_in_range, s2_tok_reg.valid, 32'(s2_d_reg) < 32'(eff_nd))
    `SBM_ASSERT_NXT(a_done_waits, (state_reg == sbm_pkg::ST_DONE) && out_valid_reg && !out_ready, state_reg == sbm_pkg::ST_DONE)

endmodule
